[hw/rtl/fpa_pkg.sv]
package fpa_pkg;

   // Default fraction width of the raw fixed-point values
   localparam int FRAC_BITS_DEFAULT = 8;

   // Operation codes
   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_DIV  = 4'd3;
   localparam logic [3:0] OP_GT   = 4'd4;
   localparam logic [3:0] OP_LT   = 4'd5;
   localparam logic [3:0] OP_GE   = 4'd6;
   localparam logic [3:0] OP_LE   = 4'd7;
   localparam logic [3:0] OP_EQ   = 4'd8;
   localparam logic [3:0] OP_NE   = 4'd9;
   localparam logic [3:0] OP_MIN  = 4'd10;
   localparam logic [3:0] OP_MAX  = 4'd11;
   localparam logic [3:0] OP_INC  = 4'd12;
   localparam logic [3:0] OP_DEC  = 4'd13;
   localparam logic [3:0] OP_FINT = 4'd14;
   localparam logic [3:0] OP_TINT = 4'd15;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } fpa_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic [1:0]         status;
   } fpa_rsp_type;

   // Side data carried alongside the divider stages
   typedef struct packed {
      logic [3:0]  op;
      fpa_rsp_type simple;
      logic [63:0] prod;
      logic        neg;
      logic        div_zero;
   } fpa_side_type;

endpackage

[hw/rtl/fpa_front.sv]
module fpa_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_vld,
   input  fpa_pkg::fpa_req_type     in_req,
   output logic                     out_vld,
   output fpa_pkg::fpa_side_type    out_side,
   output logic [32+FRAC_BITS-1:0]  out_num,
   output logic [31:0]              out_den
);
   import fpa_pkg::*;

   localparam int NW = 32 + FRAC_BITS;

   logic                  vld_ff, vld_in;
   fpa_side_type          side_ff, side_in;
   logic [NW-1:0]         num_ff, num_in;
   logic [31:0]           den_ff, den_in;

   logic signed [31:0] a, b;
   logic signed [32:0] sum, dif, incv, decv;
   logic signed [31:0] fint_top;
   logic [31:0]        mag_a, mag_b;

   // Decode the simple operations and form magnitudes
   always_comb begin
      a        = in_req.operand_a;
      b        = in_req.operand_b;
      sum      = {a[31], a} + {b[31], b};
      dif      = {a[31], a} - {b[31], b};
      incv     = {a[31], a} + 33'sd1;
      decv     = {a[31], a} - 33'sd1;
      fint_top = a >>> (31 - FRAC_BITS);
      mag_a    = a[31] ? 32'(-a) : 32'(a);
      mag_b    = b[31] ? 32'(-b) : 32'(b);

      side_in                     = '0;
      side_in.op                  = in_req.req_type;
      side_in.simple.status       = ST_OK;
      side_in.simple.compare_true = 1'b0;
      side_in.simple.result_value = '0;
      unique case (in_req.req_type)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            logic signed [32:0] v;
            unique case (in_req.req_type)
               OP_ADD:  v = sum;
               OP_SUB:  v = dif;
               OP_INC:  v = incv;
               default: v = decv;
            endcase
            if (v[32] != v[31]) begin
               side_in.simple.status       = ST_SAT;
               side_in.simple.result_value = v[32] ? VAL_MIN : VAL_MAX;
            end else begin
               side_in.simple.result_value = v[31:0];
            end
         end
         OP_GT: side_in.simple.compare_true = a > b;
         OP_LT: side_in.simple.compare_true = a < b;
         OP_GE: side_in.simple.compare_true = a >= b;
         OP_LE: side_in.simple.compare_true = a <= b;
         OP_EQ: side_in.simple.compare_true = a == b;
         OP_NE: side_in.simple.compare_true = a != b;
         OP_MIN: side_in.simple.result_value = (a < b) ? a : b;
         OP_MAX: side_in.simple.result_value = (a > b) ? a : b;
         OP_FINT: begin
            if (fint_top != '0 && fint_top != '1) begin
               side_in.simple.status       = ST_SAT;
               side_in.simple.result_value = a[31] ? VAL_MIN : VAL_MAX;
            end else begin
               side_in.simple.result_value = a <<< FRAC_BITS;
            end
         end
         OP_TINT: side_in.simple.result_value = a >>> FRAC_BITS;
         default: ;
      endcase
      side_in.prod     = 64'(mag_a) * 64'(mag_b);
      side_in.neg      = a[31] ^ b[31];
      side_in.div_zero = (b == '0);
      num_in           = {mag_a, {FRAC_BITS{1'b0}}};
      den_in           = mag_b;
      vld_in           = in_vld;
   end

   // Advance the stage when the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_side = side_ff;
   assign out_num  = num_ff;
   assign out_den  = den_ff;

endmodule

[hw/rtl/fpa_div.sv]
module fpa_div #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_vld,
   input  fpa_pkg::fpa_side_type    in_side,
   input  logic [32+FRAC_BITS-1:0]  in_num,
   input  logic [31:0]              in_den,
   output logic                     out_vld,
   output fpa_pkg::fpa_side_type    out_side,
   output logic [32+FRAC_BITS-1:0]  out_quo,
   output logic [31:0]              out_rem,
   output logic [31:0]              out_den
);
   import fpa_pkg::*;

   localparam int NW = 32 + FRAC_BITS;

   // One quotient bit per stage, restoring division
   logic               vld_ff  [NW];
   fpa_side_type       side_ff [NW];
   logic [NW-1:0]      nq_ff   [NW];
   logic [31:0]        rem_ff  [NW];
   logic [31:0]        den_ff  [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic               vld_i;
      fpa_side_type       side_i;
      logic [NW-1:0]      nq_i, nq_in;
      logic [31:0]        rem_i, den_i, rem_in;
      logic [32:0]        shifted;
      logic               ge;

      if (i == 0) begin : g_first
         assign vld_i  = in_vld;
         assign side_i = in_side;
         assign nq_i   = in_num;
         assign rem_i  = '0;
         assign den_i  = in_den;
      end else begin : g_next
         assign vld_i  = vld_ff[i-1];
         assign side_i = side_ff[i-1];
         assign nq_i   = nq_ff[i-1];
         assign rem_i  = rem_ff[i-1];
         assign den_i  = den_ff[i-1];
      end

      // Trial subtract of the divisor from the shifted remainder
      always_comb begin
         shifted = {rem_i, nq_i[NW-1]};
         ge      = shifted >= {1'b0, den_i};
         rem_in  = ge ? 32'(shifted - {1'b0, den_i}) : shifted[31:0];
         nq_in   = {nq_i[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_i;
         end
         if (adv) begin
            side_ff[i] <= side_i;
            nq_ff[i]   <= nq_in;
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_i;
         end
      end
   end

   assign out_vld  = vld_ff[NW-1];
   assign out_side = side_ff[NW-1];
   assign out_quo  = nq_ff[NW-1];
   assign out_rem  = rem_ff[NW-1];
   assign out_den  = den_ff[NW-1];

endmodule

[hw/rtl/fpa_back.sv]
module fpa_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_vld,
   input  fpa_pkg::fpa_side_type    in_side,
   input  logic [32+FRAC_BITS-1:0]  in_quo,
   input  logic [31:0]              in_rem,
   input  logic [31:0]              in_den,
   output logic                     out_vld,
   output fpa_pkg::fpa_rsp_type     out_rsp
);
   import fpa_pkg::*;

   localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

   logic          vld_ff, vld_in;
   fpa_rsp_type   rsp_ff, rsp_in;
   logic          round_up;
   logic [63:0]   mag;

   // Round, apply sign and saturate the multiply or divide result
   always_comb begin
      round_up = {in_rem, 1'b0} >= {1'b0, in_den};
      if (in_side.op == OP_MUL) begin
         mag = (in_side.prod + HALF) >> FRAC_BITS;
      end else begin
         mag = 64'(in_quo) + 64'(round_up);
      end

      rsp_in = in_side.simple;
      if (in_side.op == OP_MUL || in_side.op == OP_DIV) begin
         rsp_in.compare_true = 1'b0;
         priority if (in_side.op == OP_DIV && in_side.div_zero) begin
            rsp_in.result_value = '0;
            rsp_in.status       = ST_DIV0;
         end else if (in_side.neg && mag > 64'h8000_0000) begin
            rsp_in.result_value = VAL_MIN;
            rsp_in.status       = ST_SAT;
         end else if (!in_side.neg && mag > 64'h7fff_ffff) begin
            rsp_in.result_value = VAL_MAX;
            rsp_in.status       = ST_SAT;
         end else begin
            rsp_in.result_value = in_side.neg ? -mag[31:0] : mag[31:0];
            rsp_in.status       = ST_OK;
         end
      end
      vld_in = in_vld;
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_rsp = rsp_ff;

endmodule

[hw/rtl/fixed_point_alu.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (fpa_req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (fpa_rsp_type)
//
// One transaction enters per cycle while the output is not stalled; each result passes
// one input stage, 32 + FRAC_BITS divider stages (one quotient bit per stage) and one
// output stage before it is valid.
// Reset clears all stage valid bits; no clearing pass is needed.
// A stalled output freezes the whole pipe; req_ready falls with it.
module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fpa_pkg::fpa_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fpa_pkg::fpa_rsp_type  rsp_data
);
   import fpa_pkg::*;

   localparam int NW = 32 + FRAC_BITS;

   logic          adv;
   logic          f_vld, d_vld;
   fpa_side_type  f_side, d_side;
   logic [NW-1:0] f_num, d_quo;
   logic [31:0]   f_den, d_rem, d_den;

   // Move the whole pipe unless a result is waiting
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_valid),
      .in_req   (req_data),
      .out_vld  (f_vld),
      .out_side (f_side),
      .out_num  (f_num),
      .out_den  (f_den)
   );

   fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (f_vld),
      .in_side  (f_side),
      .in_num   (f_num),
      .in_den   (f_den),
      .out_vld  (d_vld),
      .out_side (d_side),
      .out_quo  (d_quo),
      .out_rem  (d_rem),
      .out_den  (d_den)
   );

   fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (d_vld),
      .in_side  (d_side),
      .in_quo   (d_quo),
      .in_rem   (d_rem),
      .in_den   (d_den),
      .out_vld  (rsp_valid),
      .out_rsp  (rsp_data)
   );

endmodule
